[hdl/ethernet_header_parser_unit_macros.svh]
// Assertion helpers for the Ethernet header parser.
`ifndef ETHERNET_HEADER_PARSER_UNIT_MACROS_SVH
`define ETHERNET_HEADER_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EHP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define EHP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ehp_pkg.sv]
// ----------------------------------------------------------------------------
// ehp_pkg
// Shared constants for the Ethernet header parser.
// ----------------------------------------------------------------------------
package ehp_pkg;

    localparam int MAX_FRAME_BYTES = 16384;
    // The byte counter never stops below 255 so every header offset stays reachable.
    localparam int COUNT_MAX       = (MAX_FRAME_BYTES > 255) ? MAX_FRAME_BYTES : 255;
    localparam int CNT_W           = $clog2(COUNT_MAX + 1);
    localparam int LEN_W           = 15;
    localparam int MASK_W          = 18;

    localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(COUNT_MAX);
    localparam logic [CNT_W-1:0] LEN_LIMIT   = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] MIN_FRAME   = CNT_W'(14);

    localparam logic [15:0] TPID_VLAN   = 16'h8100;
    localparam logic [15:0] TYPE_MIN    = 16'h0600;
    localparam logic [15:0] ET_IPV4     = 16'h0800;
    localparam logic [15:0] ET_IPV6     = 16'h86DD;
    localparam logic [15:0] ET_ARP      = 16'h0806;
    localparam logic [15:0] ET_LLDP     = 16'h88CC;
    localparam logic [15:0] ET_SLOW     = 16'h8809;
    localparam logic [7:0]  SAP_SNAP0   = 8'hAA;
    localparam logic [7:0]  SAP_SNAP1   = 8'hAB;
    localparam logic [7:0]  PROTO_ICMP  = 8'd1;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [15:0] PORT_BOOTPS = 16'd67;
    localparam logic [15:0] PORT_BOOTPC = 16'd68;
    localparam logic [7:0]  SUB_LACP    = 8'd1;

    localparam int B_META   = 0;
    localparam int B_ETH    = 1;
    localparam int B_VLAN   = 2;
    localparam int B_ETHER  = 3;
    localparam int B_LLC    = 4;
    localparam int B_SNAP   = 5;
    localparam int B_NOTYPE = 6;
    localparam int B_IP4    = 7;
    localparam int B_IP6    = 8;
    localparam int B_ARP    = 9;
    localparam int B_LLDP   = 10;
    localparam int B_SLOW   = 11;
    localparam int B_LACP   = 12;
    localparam int B_ICMP   = 13;
    localparam int B_TCP    = 14;
    localparam int B_UDP    = 15;
    localparam int B_L4     = 16;
    localparam int B_DHCP   = 17;

    typedef logic [MASK_W-1:0] t_mask;

endpackage

[hdl/ehp_byte_if.sv]
// ----------------------------------------------------------------------------
// ehp_byte_if
// Frame byte channel: one word per frame byte.
// ----------------------------------------------------------------------------
interface ehp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

[hdl/ehp_result_if.sv]
// ----------------------------------------------------------------------------
// ehp_result_if
// Parse result channel: one word per frame.
// ----------------------------------------------------------------------------
interface ehp_result_if;
    import ehp_pkg::*;
    logic        valid;
    logic        ready;
    t_mask       hdr_flags;
    logic        vlan_tagged;
    logic        too_short;
    logic        truncated;
    logic [14:0] frame_length;
    logic [7:0]  ether_offset;
    logic [7:0]  llc_offset;
    logic [7:0]  l3_offset;
    logic [7:0]  l4_offset;
    logic [7:0]  dhcp_offset;

    modport source (output valid, hdr_flags, vlan_tagged, too_short, truncated,
                    frame_length, ether_offset, llc_offset, l3_offset, l4_offset,
                    dhcp_offset, input ready);
    modport sink   (input valid, hdr_flags, vlan_tagged, too_short, truncated,
                    frame_length, ether_offset, llc_offset, l3_offset, l4_offset,
                    dhcp_offset, output ready);
endinterface

[hdl/ethernet_header_parser_unit.sv]
// The result word is registered as the last byte is taken and is valid in the cycle after.
// Throughput: one byte per cycle while no result is stalled; each byte updates the parse state in one pass.
// The result register frees the input: a byte is taken unless a result is stalled.
// Reset (synchronous, active low) returns the parser to idle with no result pending.
// ----------------------------------------------------------------------------
// ethernet_header_parser_unit
// Byte-serial Ethernet/VLAN/LLC/SNAP/IP/L4 header walker with a result register.
// ----------------------------------------------------------------------------
`include "ethernet_header_parser_unit_macros.svh"

module ethernet_header_parser_unit
    import ehp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ehp_byte_if.sink     i_in,
    ehp_result_if.source o_res
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_ETYPE, PH_VTYPE, PH_LLC, PH_OUI, PH_SNAPTYPE, PH_IHL,
        PH_IP4PROTO, PH_IP6NH, PH_SPORT, PH_SLOW, PH_DONE
    } t_phase;

    localparam int OFS_ETHER = 0;
    localparam int OFS_LLC   = 1;
    localparam int OFS_L3    = 2;
    localparam int OFS_L4    = 3;
    localparam int OFS_DHCP  = 4;

    typedef logic [7:0] t_ofs [5];

    t_phase           r_phase, n_phase, b_phase, d_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt, b_cnt, len_sat;
    logic [7:0]       r_nd, n_nd, b_nd;
    logic [23:0]      r_sh, n_sh, b_sh;
    t_mask            r_mask, n_mask, b_mask;
    t_ofs             r_ofs, n_ofs, b_ofs;
    logic             r_vlan, n_vlan, b_vlan;

    logic             r_ov;
    t_mask            r_o_mask;
    logic             r_o_vlan, r_o_short, r_o_trunc;
    logic [14:0]      r_o_len;
    t_ofs             r_o_ofs;

    logic             in_fire;
    logic [7:0]       p8, v8, tl_base, et_l3, l4_new;
    logic [15:0]      v16, et_val;
    logic             do_tl, do_et, do_ip, short_frame;

    assign i_in.ready = !r_ov || o_res.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    always_comb begin
        n_phase = r_phase;
        d_phase = r_phase;
        n_cnt   = r_cnt;
        n_nd    = r_nd;
        n_sh    = r_sh;
        n_mask  = r_mask;
        n_ofs   = r_ofs;
        n_vlan  = r_vlan;
        do_tl   = 1'b0;
        do_et   = 1'b0;
        do_ip   = 1'b0;
        tl_base = 8'd0;
        et_l3   = 8'd0;
        et_val  = 16'd0;
        l4_new  = 8'd0;
        // A frame starts from a cleared state that waits for the type field.
        if (r_phase == PH_IDLE) begin
            b_phase = PH_ETYPE;
            b_cnt   = '0;
            b_nd    = 8'd13;
            b_sh    = '0;
            b_mask  = '0;
            b_mask[B_META] = 1'b1;
            b_mask[B_ETH]  = 1'b1;
            b_ofs   = '{default: 8'd0};
            b_vlan  = 1'b0;
        end else begin
            b_phase = r_phase;
            b_cnt   = r_cnt;
            b_nd    = r_nd;
            b_sh    = r_sh;
            b_mask  = r_mask;
            b_ofs   = r_ofs;
            b_vlan  = r_vlan;
        end
        p8  = b_cnt[7:0];
        v8  = i_in.data_byte;
        v16 = {b_sh[7:0], i_in.data_byte};
        if (in_fire) begin
            n_phase = b_phase;
            n_nd    = b_nd;
            n_mask  = b_mask;
            n_ofs   = b_ofs;
            n_vlan  = b_vlan;
            n_cnt   = (b_cnt < COUNT_LIMIT) ? b_cnt + 1'b1 : b_cnt;
            n_sh    = {b_sh[15:0], i_in.data_byte};
            if (b_phase != PH_DONE && b_cnt == CNT_W'(b_nd)) begin
                case (b_phase)
                    PH_ETYPE: begin
                        if (v16 == TPID_VLAN) begin
                            n_vlan = 1'b1;
                            n_mask[B_VLAN] = 1'b1;
                            n_phase = PH_VTYPE;
                            n_nd = 8'd17;
                        end else begin
                            do_tl = 1'b1;
                            tl_base = 8'd12;
                        end
                    end
                    PH_VTYPE: begin
                        do_tl = 1'b1;
                        tl_base = 8'd16;
                    end
                    PH_LLC: begin
                        if (v16[15:8] == SAP_SNAP0 || v16[15:8] == SAP_SNAP1 ||
                            v8 == SAP_SNAP0 || v8 == SAP_SNAP1) begin
                            n_mask[B_SNAP] = 1'b1;
                            n_phase = PH_OUI;
                            n_nd = p8 + 8'd4;
                        end else begin
                            n_mask[B_NOTYPE] = 1'b1;
                            n_phase = PH_DONE;
                        end
                    end
                    PH_OUI: begin
                        if (n_sh == 24'd0) begin
                            n_phase = PH_SNAPTYPE;
                            n_nd = p8 + 8'd2;
                        end else begin
                            n_mask[B_NOTYPE] = 1'b1;
                            n_phase = PH_DONE;
                        end
                    end
                    PH_SNAPTYPE: begin
                        n_mask[B_ETHER] = 1'b1;
                        n_ofs[OFS_ETHER] = p8 - 8'd1;
                        do_et = 1'b1;
                        et_val = v16;
                        et_l3 = p8 + 8'd1;
                    end
                    PH_IHL: begin
                        if (v8[3:0] < 4'd5) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_ofs[OFS_L4] = p8 + {2'b00, v8[3:0], 2'b00};
                            n_phase = PH_IP4PROTO;
                            n_nd = p8 + 8'd9;
                        end
                    end
                    PH_IP4PROTO, PH_IP6NH: do_ip = 1'b1;
                    PH_SPORT: begin
                        if (v16 == PORT_BOOTPS || v16 == PORT_BOOTPC) begin
                            n_mask[B_DHCP] = 1'b1;
                            n_ofs[OFS_DHCP] = b_ofs[OFS_L4] + 8'd8;
                        end
                        n_phase = PH_DONE;
                    end
                    PH_SLOW: begin
                        if (v8 == SUB_LACP) begin
                            n_mask[B_LACP] = 1'b1;
                        end
                        n_phase = PH_DONE;
                    end
                    default: n_phase = PH_DONE;
                endcase
            end
            if (do_tl) begin
                if (v16 >= TYPE_MIN) begin
                    n_mask[B_ETHER] = 1'b1;
                    n_ofs[OFS_ETHER] = tl_base;
                    do_et = 1'b1;
                    et_val = v16;
                    et_l3 = tl_base + 8'd2;
                end else begin
                    n_mask[B_LLC] = 1'b1;
                    n_ofs[OFS_LLC] = tl_base;
                    n_phase = PH_LLC;
                    n_nd = tl_base + 8'd3;
                end
            end
            if (do_et) begin
                n_phase = PH_DONE;
                case (et_val)
                    ET_IPV4: begin
                        n_mask[B_IP4] = 1'b1;
                        n_ofs[OFS_L3] = et_l3;
                        n_phase = PH_IHL;
                        n_nd = et_l3;
                    end
                    ET_IPV6: begin
                        n_mask[B_IP6] = 1'b1;
                        n_ofs[OFS_L3] = et_l3;
                        n_ofs[OFS_L4] = et_l3 + 8'd40;
                        n_phase = PH_IP6NH;
                        n_nd = et_l3 + 8'd6;
                    end
                    ET_ARP: begin
                        n_mask[B_ARP] = 1'b1;
                        n_ofs[OFS_L3] = et_l3;
                    end
                    ET_LLDP: begin
                        n_mask[B_LLDP] = 1'b1;
                        n_ofs[OFS_L3] = et_l3;
                    end
                    ET_SLOW: begin
                        n_mask[B_SLOW] = 1'b1;
                        n_ofs[OFS_L3] = et_l3;
                        n_phase = PH_SLOW;
                        n_nd = et_l3;
                    end
                    default: n_phase = PH_DONE;
                endcase
            end
            if (do_ip) begin
                n_phase = PH_DONE;
                l4_new = b_ofs[OFS_L4] + 8'd1;
                case (v8)
                    PROTO_ICMP: n_mask[B_ICMP] = 1'b1;
                    PROTO_TCP: begin
                        n_mask[B_TCP] = 1'b1;
                        n_mask[B_L4] = 1'b1;
                    end
                    PROTO_UDP: begin
                        n_mask[B_UDP] = 1'b1;
                        n_mask[B_L4] = 1'b1;
                        n_phase = PH_SPORT;
                        n_nd = l4_new;
                    end
                    default: n_phase = PH_DONE;
                endcase
            end
            // Truncation is judged on the phase after the decision, before the
            // end-of-frame return to idle.
            d_phase = n_phase;
            if (i_in.last_byte) begin
                n_phase = PH_IDLE;
            end
        end
    end

    assign short_frame = n_cnt < MIN_FRAME;
    assign len_sat     = (n_cnt < LEN_LIMIT) ? n_cnt : LEN_LIMIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_nd    <= '0;
            r_sh    <= '0;
            r_mask  <= '0;
            r_ofs   <= '{default: 8'd0};
            r_vlan  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_nd    <= n_nd;
            r_sh    <= n_sh;
            r_mask  <= n_mask;
            r_ofs   <= n_ofs;
            r_vlan  <= n_vlan;
            if (in_fire && i_in.last_byte) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Result word; offsets read as zero when their header bit is clear.
    always_ff @(posedge i_clk) begin
        if (in_fire && i_in.last_byte) begin
            r_o_short <= short_frame;
            r_o_len   <= LEN_W'(len_sat);
            r_o_mask  <= short_frame ? '0 : n_mask;
            r_o_vlan  <= !short_frame && n_vlan;
            r_o_trunc <= !short_frame && d_phase != PH_DONE;
            r_o_ofs[OFS_ETHER] <= (!short_frame && n_mask[B_ETHER]) ?
                                  n_ofs[OFS_ETHER] : 8'd0;
            r_o_ofs[OFS_LLC]   <= (!short_frame && n_mask[B_LLC]) ?
                                  n_ofs[OFS_LLC] : 8'd0;
            r_o_ofs[OFS_L3]    <= (!short_frame && (n_mask[B_IP4] || n_mask[B_IP6] ||
                                   n_mask[B_ARP] || n_mask[B_LLDP] || n_mask[B_SLOW])) ?
                                  n_ofs[OFS_L3] : 8'd0;
            r_o_ofs[OFS_L4]    <= (!short_frame && (n_mask[B_ICMP] || n_mask[B_TCP] ||
                                   n_mask[B_UDP])) ? n_ofs[OFS_L4] : 8'd0;
            r_o_ofs[OFS_DHCP]  <= (!short_frame && n_mask[B_DHCP]) ?
                                  n_ofs[OFS_DHCP] : 8'd0;
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.hdr_flags    = r_o_mask;
    assign o_res.vlan_tagged  = r_o_vlan;
    assign o_res.too_short    = r_o_short;
    assign o_res.truncated    = r_o_trunc;
    assign o_res.frame_length = r_o_len;
    assign o_res.ether_offset = r_o_ofs[OFS_ETHER];
    assign o_res.llc_offset   = r_o_ofs[OFS_LLC];
    assign o_res.l3_offset    = r_o_ofs[OFS_L3];
    assign o_res.l4_offset    = r_o_ofs[OFS_L4];
    assign o_res.dhcp_offset  = r_o_ofs[OFS_DHCP];

    `EHP_ASSERT_NXT(a_res_from_last, i_clk, i_rst_n, in_fire && i_in.last_byte, r_ov, "no result")
    `EHP_ASSERT_IMP(a_short_empty, i_clk, i_rst_n, r_ov && r_o_short, r_o_mask == '0 && !r_o_trunc, "short")
    `EHP_ASSERT_IMP(a_dhcp_udp, i_clk, i_rst_n, r_ov && r_o_mask[B_DHCP], r_o_mask[B_UDP], "DHCP w/o UDP")
    `EHP_ASSERT_NXT(a_idle_after_last, i_clk, i_rst_n, in_fire && i_in.last_byte, r_phase == PH_IDLE, "not idle")

endmodule
